>>> rtl/core/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg: shared types and constants of the planar rod derivative block
// Fixed-point formats, register indexes, CORDIC constants and arithmetic
// helpers used by the pipeline.
// ----------------------------------------------------------------------------
package prd_pkg;

	localparam int FracBits    = 16;
	localparam int CordicSteps = 18;
	localparam int AngBits     = 30;
	localparam int StepsDone   = (CordicSteps < 31) ? CordicSteps : 31;

	localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
	localparam logic signed [33:0] GainQ30   = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_STIFF_00 = 3'd0,
		REG_STIFF_01 = 3'd1,
		REG_STIFF_10 = 3'd2,
		REG_STIFF_11 = 3'd3,
		REG_BEND     = 3'd4,
		REG_LENGTH   = 3'd5
	} reg_idx_t;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_beat_t;

	typedef struct packed {
		logic [18:0] rod_angle;
		logic [31:0] force_x;
		logic [31:0] force_y;
		logic [31:0] moment;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] pos_x_rate;
		logic [31:0] pos_y_rate;
		logic [31:0] angle_rate;
		logic [31:0] moment_rate;
		logic        saturated;
	} out_beat_t;

	function automatic logic signed [35:0] atan_q30(input int i);
		logic signed [35:0] r;
		case (i)
			0: r = 36'h03243F6A8;
			1: r = 36'h01DAC6705;
			2: r = 36'h00FADBAFC;
			3: r = 36'h007F56EA6;
			4: r = 36'h003FEAB76;
			5: r = 36'h001FFD55B;
			6: r = 36'h000FFFAAA;
			7: r = 36'h0007FFF55;
			8: r = 36'h0003FFFEA;
			9: r = 36'h0001FFFFD;
			27: r = 36'h8;
			28: r = 36'h4;
			29: r = 36'h2;
			30: r = 36'h1;
			default: r = (36'sd1 << (30 - i)) - 36'sd1;
		endcase
		return r;
	endfunction

	// Rounded product: add half an LSB, then arithmetic shift.
	function automatic logic signed [63:0] mulr(input logic signed [63:0] p,
			input int sh);
		logic signed [63:0] r;
		r = (p + (64'sd1 <<< (sh - 1))) >>> sh;
		return r;
	endfunction

	function automatic q_t sat32(input logic signed [63:0] v);
		q_t r;
		if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -64'sh80000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic clip32(input logic signed [63:0] v);
		return (v > 64'sh7FFFFFFF) || (v < -64'sh80000000);
	endfunction

endpackage

>>> rtl/core/prd_if.sv
// ----------------------------------------------------------------------------
// prd_if: valid/ready channels of the planar rod derivative block
// One interface per payload type, each with source and sink modports.
// ----------------------------------------------------------------------------
interface prd_in_if;
	logic               valid;
	logic               ready;
	prd_pkg::in_beat_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prd_out_if;
	logic               valid;
	logic               ready;
	prd_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prd_cfg_if;
	logic               valid;
	logic               ready;
	prd_pkg::cfg_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/planar_rod_derivative.sv
// ----------------------------------------------------------------------------
// planar_rod_derivative: right-hand side of the planar Cosserat rod ODE
// Rotates the force into the body frame, applies inverse stiffness and unit
// axial strain, rotates back and scales by length; gives angle and moment rate.
// ----------------------------------------------------------------------------
// One rod state is accepted per clock and one result leaves per clock while
// the output is not stalled. The stages are one for range reduction, eighteen
// CORDIC rotation stages, then nine arithmetic stages, the last of them the
// output register, in which ranks of 32x34 or 32x32 multipliers alternate
// with rounding, summing and saturation. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall at the
// output holds every stage in place. Configuration registers must only be
// written while the pipeline is empty.
module planar_rod_derivative (
	input  logic           clk,
	input  logic           arst_n,
	prd_cfg_if.sink        cfg,
	prd_in_if.sink         rod_in,
	prd_out_if.source      rod_out
);

	localparam int NC = prd_pkg::StepsDone + 1;
	// Arithmetic stages before the output register.
	localparam int NA = 8;
	localparam int NV = NC + NA;

	prd_pkg::q_t       k00_q, k01_q, k10_q, k11_q;
	logic [30:0]       bend_q, len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k00_q  <= 32'sd65536;
			k01_q  <= '0;
			k10_q  <= '0;
			k11_q  <= 32'sd65536;
			bend_q <= 31'd65536;
			len_q  <= 31'd65536;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				prd_pkg::REG_STIFF_00: k00_q <= cfg.data.data;
				prd_pkg::REG_STIFF_01: k01_q <= cfg.data.data;
				prd_pkg::REG_STIFF_10: k10_q <= cfg.data.data;
				prd_pkg::REG_STIFF_11: k11_q <= cfg.data.data;
				prd_pkg::REG_BEND:     bend_q <= cfg.data.data[30:0];
				prd_pkg::REG_LENGTH:   len_q <= cfg.data.data[30:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic [NV-1:0] vld_q;
	logic out_vld_q;

	assign en = !out_vld_q || rod_out.ready;
	assign rod_in.ready = en;
	assign rod_out.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], rod_in.valid};
			out_vld_q <= vld_q[NV-1];
		end
	end

	// Forces and moment travel alongside the CORDIC.
	prd_pkg::q_t nx_d [0:NC-1];
	prd_pkg::q_t ny_d [0:NC-1];
	prd_pkg::q_t m_d  [0:NC-1];

	always_ff @(posedge clk) begin
		if (en) begin
			nx_d[0] <= rod_in.data.force_x;
			ny_d[0] <= rod_in.data.force_y;
			m_d[0]  <= rod_in.data.moment;
			for (int i = 1; i < NC; i++) begin
				nx_d[i] <= nx_d[i-1];
				ny_d[i] <= ny_d[i-1];
				m_d[i]  <= m_d[i-1];
			end
		end
	end

	logic signed [33:0] c, s;

	prd_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (rod_in.data.rod_angle),
		.cos_q (c),
		.sin_q (s)
	);

	prd_pkg::q_t nx, ny, m;
	assign nx = nx_d[NC-1];
	assign ny = ny_d[NC-1];
	assign m  = m_d[NC-1];

	// a1: body-frame force products; moment scaled by compliance.
	logic signed [63:0] p_cx_s1, p_sy_s1, p_cy_s1, p_sx_s1, p_mb_s1;
	logic signed [33:0] c_s1, s_s1;
	prd_pkg::q_t nx_s1, ny_s1;
	// a2
	prd_pkg::q_t bx_s2, by_s2, t0_s2, nx_s2, ny_s2;
	logic signed [33:0] c_s2, s_s2;
	logic f_s2;
	// a3: stiffness products
	logic signed [63:0] p00_s3, p01_s3, p10_s3, p11_s3;
	prd_pkg::q_t t0_s3, nx_s3, ny_s3;
	logic signed [33:0] c_s3, s_s3;
	logic f_s3;
	// a4
	prd_pkg::q_t vx_s4, vy_s4, t0_s4, nx_s4, ny_s4;
	logic signed [33:0] c_s4, s_s4;
	logic f_s4;
	// a5: rotation back
	logic signed [63:0] p_cvx_s5, p_svy_s5, p_svx_s5, p_cvy_s5;
	prd_pkg::q_t t0_s5, nx_s5, ny_s5;
	logic f_s5;
	// a6
	prd_pkg::q_t ux_s6, uy_s6, t0_s6, nx_s6, ny_s6;
	logic f_s6;
	// a7: length scaling
	prd_pkg::q_t px_s7, py_s7, th_s7, nx_s7, ny_s7;
	logic f_s7;
	// a8: moment rate products
	logic signed [63:0] p_pyn_s8, p_pxn_s8;
	prd_pkg::q_t px_s8, py_s8, th_s8;
	logic f_s8;

	logic signed [63:0] sum_bx, sum_by, sum_vx, sum_vy, sum_ux, sum_uy;
	logic signed [63:0] sum_px, sum_py, sum_th, sum_t0, sum_ms;
	prd_pkg::out_beat_t out_q;

	always_comb begin
		sum_bx = prd_pkg::mulr(p_cx_s1, prd_pkg::AngBits)
			+ prd_pkg::mulr(p_sy_s1, prd_pkg::AngBits);
		sum_by = prd_pkg::mulr(p_cy_s1, prd_pkg::AngBits)
			- prd_pkg::mulr(p_sx_s1, prd_pkg::AngBits);
		sum_t0 = prd_pkg::mulr(p_mb_s1, prd_pkg::FracBits);
		sum_vx = prd_pkg::mulr(p00_s3, prd_pkg::FracBits)
			+ prd_pkg::mulr(p01_s3, prd_pkg::FracBits);
		sum_vy = prd_pkg::mulr(p10_s3, prd_pkg::FracBits)
			+ prd_pkg::mulr(p11_s3, prd_pkg::FracBits)
			+ (64'sd1 <<< prd_pkg::FracBits);
		sum_ux = prd_pkg::mulr(p_cvx_s5, prd_pkg::AngBits)
			- prd_pkg::mulr(p_svy_s5, prd_pkg::AngBits);
		sum_uy = prd_pkg::mulr(p_svx_s5, prd_pkg::AngBits)
			+ prd_pkg::mulr(p_cvy_s5, prd_pkg::AngBits);
		sum_px = prd_pkg::mulr(64'(ux_s6) * 64'(signed'({1'b0, len_q})),
			prd_pkg::FracBits);
		sum_py = prd_pkg::mulr(64'(uy_s6) * 64'(signed'({1'b0, len_q})),
			prd_pkg::FracBits);
		sum_th = prd_pkg::mulr(64'(t0_s6) * 64'(signed'({1'b0, len_q})),
			prd_pkg::FracBits);
		sum_ms = prd_pkg::mulr(p_pyn_s8, prd_pkg::FracBits)
			- prd_pkg::mulr(p_pxn_s8, prd_pkg::FracBits);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_cx_s1 <= 64'(c) * 64'(nx);
			p_sy_s1 <= 64'(s) * 64'(ny);
			p_cy_s1 <= 64'(c) * 64'(ny);
			p_sx_s1 <= 64'(s) * 64'(nx);
			p_mb_s1 <= 64'(m) * 64'(signed'({1'b0, bend_q}));
			c_s1 <= c; s_s1 <= s; nx_s1 <= nx; ny_s1 <= ny;

			bx_s2 <= prd_pkg::sat32(sum_bx);
			by_s2 <= prd_pkg::sat32(sum_by);
			t0_s2 <= prd_pkg::sat32(sum_t0);
			f_s2 <= prd_pkg::clip32(sum_bx) | prd_pkg::clip32(sum_by)
				| prd_pkg::clip32(sum_t0);
			c_s2 <= c_s1; s_s2 <= s_s1; nx_s2 <= nx_s1; ny_s2 <= ny_s1;

			p00_s3 <= 64'(k00_q) * 64'(bx_s2);
			p01_s3 <= 64'(k01_q) * 64'(by_s2);
			p10_s3 <= 64'(k10_q) * 64'(bx_s2);
			p11_s3 <= 64'(k11_q) * 64'(by_s2);
			t0_s3 <= t0_s2; nx_s3 <= nx_s2; ny_s3 <= ny_s2;
			c_s3 <= c_s2; s_s3 <= s_s2; f_s3 <= f_s2;

			vx_s4 <= prd_pkg::sat32(sum_vx);
			vy_s4 <= prd_pkg::sat32(sum_vy);
			f_s4 <= f_s3 | prd_pkg::clip32(sum_vx) | prd_pkg::clip32(sum_vy);
			t0_s4 <= t0_s3; nx_s4 <= nx_s3; ny_s4 <= ny_s3;
			c_s4 <= c_s3; s_s4 <= s_s3;

			p_cvx_s5 <= 64'(c_s4) * 64'(vx_s4);
			p_svy_s5 <= 64'(s_s4) * 64'(vy_s4);
			p_svx_s5 <= 64'(s_s4) * 64'(vx_s4);
			p_cvy_s5 <= 64'(c_s4) * 64'(vy_s4);
			t0_s5 <= t0_s4; nx_s5 <= nx_s4; ny_s5 <= ny_s4; f_s5 <= f_s4;

			ux_s6 <= prd_pkg::sat32(sum_ux);
			uy_s6 <= prd_pkg::sat32(sum_uy);
			f_s6 <= f_s5 | prd_pkg::clip32(sum_ux) | prd_pkg::clip32(sum_uy);
			t0_s6 <= t0_s5; nx_s6 <= nx_s5; ny_s6 <= ny_s5;

			px_s7 <= prd_pkg::sat32(sum_px);
			py_s7 <= prd_pkg::sat32(sum_py);
			th_s7 <= prd_pkg::sat32(sum_th);
			f_s7 <= f_s6 | prd_pkg::clip32(sum_px) | prd_pkg::clip32(sum_py)
				| prd_pkg::clip32(sum_th);
			nx_s7 <= nx_s6; ny_s7 <= ny_s6;

			p_pyn_s8 <= 64'(py_s7) * 64'(nx_s7);
			p_pxn_s8 <= 64'(px_s7) * 64'(ny_s7);
			px_s8 <= px_s7; py_s8 <= py_s7; th_s8 <= th_s7; f_s8 <= f_s7;

			out_q.pos_x_rate  <= px_s8;
			out_q.pos_y_rate  <= py_s8;
			out_q.angle_rate  <= th_s8;
			out_q.moment_rate <= prd_pkg::sat32(sum_ms);
			out_q.saturated   <= f_s8 | prd_pkg::clip32(sum_ms);
		end
	end

	assign rod_out.data = out_q;

endmodule

>>> rtl/core/prd_cordic.sv
// ----------------------------------------------------------------------------
// prd_cordic: pipelined sine and cosine
// Range reduction in the first stage, then one rotation stage per CORDIC step.
// All stages advance together under a common enable.
// ----------------------------------------------------------------------------
module prd_cordic (
	input  logic                clk,
	input  logic                en,
	input  logic signed [18:0]  angle,
	output logic signed [33:0]  cos_q,
	output logic signed [33:0]  sin_q
);

	localparam int N = prd_pkg::StepsDone;

	logic signed [35:0] z_s [0:N];
	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic               flip_s [0:N];

	logic signed [35:0] z_in, z_mod, z_red;
	logic               flip_in;

	always_comb begin
		z_in = 36'(angle) <<< (prd_pkg::AngBits - prd_pkg::FracBits);
		z_mod = z_in;
		if (z_mod > prd_pkg::PiQ30) z_mod = z_mod - prd_pkg::TwoPiQ30;
		if (z_mod < -prd_pkg::PiQ30) z_mod = z_mod + prd_pkg::TwoPiQ30;
		flip_in = 1'b0;
		z_red = z_mod;
		if (z_mod > prd_pkg::HalfPiQ30) begin
			z_red = z_mod - prd_pkg::PiQ30;
			flip_in = 1'b1;
		end else if (z_mod < -prd_pkg::HalfPiQ30) begin
			z_red = z_mod + prd_pkg::PiQ30;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= z_red;
			x_s[0] <= prd_pkg::GainQ30;
			y_s[0] <= '0;
			flip_s[0] <= flip_in;
			for (int i = 0; i < N; i++) begin
				flip_s[i+1] <= flip_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - prd_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + prd_pkg::atan_q30(i);
				end
			end
		end
	end

	assign cos_q = flip_s[N] ? -x_s[N] : x_s[N];
	assign sin_q = flip_s[N] ? -y_s[N] : y_s[N];

endmodule

>>> rtl/core/prd_checker.sv
// ----------------------------------------------------------------------------
// prd_checker: port-level checks of the planar rod derivative block
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module prd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready
);

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port refused a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_in_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline is stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

endmodule

bind planar_rod_derivative prd_checker u_prd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (rod_in.ready),
	.out_valid (rod_out.valid),
	.out_ready (rod_out.ready),
	.cfg_ready (cfg.ready)
);
